// ===== rtl/bbw_pkg.sv =====
// Shared types and constants for the B-spline basis weight block.
// Command/status structs between controller and datapath; no dependencies.
package bbw_pkg;

    localparam int MAX_ORDER_DEF = 4;
    localparam int MAX_BINS_DEF  = 64;

    // order register is 3 bits wide, so loop counters fit in 3 bits
    localparam int ORD_W  = 3;
    localparam int CFG_AW = 2;
    localparam int CFG_DW = 32;

    localparam logic [CFG_AW-1:0] REG_ORDER = 2'd0;
    localparam logic [CFG_AW-1:0] REG_BINS  = 2'd1;
    localparam logic [CFG_AW-1:0] REG_MIN   = 2'd2;
    localparam logic [CFG_AW-1:0] REG_INVR  = 2'd3;

    localparam logic [2:0]  ORDER_RST = 3'd3;
    localparam logic [6:0]  BINS_RST  = 7'd10;
    localparam logic [31:0] MIN_RST   = 32'd0;
    localparam logic [31:0] INVR_RST  = 32'd65536;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MAP1,
        OP_MAP2,
        OP_MAP3,
        OP_TERM,
        OP_DLOAD,
        OP_DSTEP,
        OP_ACC,
        OP_STORE,
        OP_ROT,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [ORD_W-1:0] lvl;
        logic [ORD_W-1:0] pos;
        logic             half;
    } t_cmd;

    typedef struct packed {
        logic             cfg_bad;
        logic [ORD_W-1:0] k_eff;
        logic             term_on;
        logic             div_last;
        logic             nz_cur;
    } t_stat;

endpackage

// ===== rtl/bbw_dp.sv =====
// Datapath: config registers, sample mapping, shared multiplier, small-divisor
// long divider and the rotating basis window. Depends on bbw_pkg.
module bbw_dp import bbw_pkg::*; #(
    parameter int MAX_ORDER = MAX_ORDER_DEF,
    parameter int MAX_BINS  = MAX_BINS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CFG_AW-1:0]  i_cfg_addr,
    input  logic [CFG_DW-1:0]  i_cfg_wdata,
    input  logic signed [31:0] i_sample,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    output logic [5:0]         o_bin_index,
    output logic [16:0]        o_weight,
    output logic               o_last
);

    localparam int NBW   = $clog2(MAX_BINS + 1);
    localparam int ZW    = NBW + 16;
    localparam int IW    = $clog2(MAX_BINS + 2 * MAX_ORDER + 2);
    localparam int SW    = $clog2(MAX_ORDER + 1);
    localparam int BVW   = 33;
    localparam int MW    = 33;
    localparam int PW    = 2 * MW;
    localparam int DVW   = ZW + 17;
    localparam int DIG   = 8;
    localparam int STEPS = (DVW + DIG - 1) / DIG;
    localparam int DVP   = STEPS * DIG;
    localparam int CNTW  = $clog2(STEPS + 1);
    localparam int WN    = MAX_ORDER + 1;

    localparam logic [BVW-1:0] ONE_Q32 = BVW'(64'h1_0000_0000);

    logic [2:0]  r_order;
    logic [6:0]  r_bins;
    logic [31:0] r_min;
    logic [31:0] r_invr;

    logic signed [31:0] r_smp;
    logic [PW-1:0]      r_p;
    logic               r_pos;
    logic               r_over;
    logic [ZW-1:0]      r_z;
    logic [SW-1:0]      r_s;
    logic [DVP-1:0]     r_dvd;
    logic [DVP-1:0]     r_quo;
    logic [SW-1:0]      r_rem;
    logic [CNTW-1:0]    r_cnt;
    logic [BVW-1:0]     r_acc;
    logic [BVW-1:0]     r_w [WN];

    logic [ORD_W-1:0] k_eff;
    logic [NBW-1:0]   nb_eff;
    logic [NBW-1:0]   tmax;
    logic [ZW-1:0]    top;
    logic             cfg_bad;
    logic signed [32:0] d;
    logic [NBW-1:0]   base;
    logic [MW-1:0]    ma;
    logic [MW-1:0]    mb;
    logic [ZW-1:0]    zc;
    logic [ZW-1:0]    z_new;

    logic [IW-1:0]  a_lo;
    logic [IW-1:0]  a_hi;
    logic [NBW-1:0] t_lo;
    logic [NBW-1:0] t_hi;
    logic [BVW-1:0] bsel;
    logic [ZW-1:0]  dz;
    logic           term_on;
    logic [DIG-1:0] qbits;
    logic [SW-1:0]  rem_nx;
    logic [16:0]    wt [WN];
    logic           nz [WN];
    logic           last_cur;

    function automatic logic [NBW-1:0] knot_at(input logic [IW-1:0] i,
                                               input logic [ORD_W-1:0] k,
                                               input logic [NBW-1:0] nb);
        logic [IW+1:0] ii;
        logic [IW+1:0] kk;
        logic [IW+1:0] nn;
        logic [IW+1:0] v;
        ii = (IW+2)'(i);
        kk = (IW+2)'(k);
        nn = (IW+2)'(nb);
        if (ii < kk) begin
            v = '0;
        end else if (ii < nn) begin
            v = ii - kk + 1'b1;
        end else begin
            v = nn - kk + 1'b1;
        end
        return v[NBW-1:0];
    endfunction

    function automatic logic [16:0] round_wt(input logic [BVW-1:0] b);
        logic [BVW:0] s;
        s = {1'b0, b} + (BVW+1)'(32768);
        if (s[BVW:16] > (BVW-15)'(65536)) begin
            return 17'd65536;
        end
        return s[32:16];
    endfunction

    // effective order and bin count
    always_comb begin
        k_eff  = (32'(r_order) > 32'(MAX_ORDER)) ? ORD_W'(MAX_ORDER) : r_order;
        nb_eff = (32'(r_bins) > 32'(MAX_BINS)) ? NBW'(MAX_BINS) : NBW'(r_bins);
        cfg_bad = (k_eff == '0) || (32'(nb_eff) < 32'(k_eff));
        tmax   = nb_eff - NBW'(k_eff) + 1'b1;
        top    = {tmax - 1'b1, 16'hFFFF};
        d      = $signed({r_smp[31], r_smp}) - $signed({r_min[31], r_min});
        base   = r_z[ZW-1:16];
    end

    // knot pair and operand for the current recursion term
    always_comb begin
        a_lo = IW'(base) + IW'(i_cmd.pos) + IW'(i_cmd.half);
        a_hi = a_lo + IW'(i_cmd.lvl);
        t_lo = knot_at(a_lo, k_eff, nb_eff);
        t_hi = knot_at(a_hi, k_eff, nb_eff);
        if (!i_cmd.half) begin
            bsel = r_w[0];
        end else if (i_cmd.pos == k_eff - 1'b1) begin
            bsel = '0;
        end else begin
            bsel = r_w[1];
        end
        if (i_cmd.half) begin
            dz      = {t_hi, 16'h0} - r_z;
            term_on = (bsel != '0) && (t_hi > t_lo) && ({t_hi, 16'h0} >= r_z);
        end else begin
            dz      = r_z - {t_lo, 16'h0};
            term_on = (bsel != '0) && (t_hi > t_lo) && (r_z >= {t_lo, 16'h0});
        end
    end

    // shared multiplier operands
    always_comb begin
        case (i_cmd.op)
            OP_MAP1: begin
                ma = {1'b0, d[31:0]};
                mb = {1'b0, r_invr};
            end
            OP_MAP2: begin
                ma = {1'b0, r_p[31:0]};
                mb = MW'(tmax);
            end
            OP_TERM: begin
                ma = MW'(dz);
                mb = bsel;
            end
            default: begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    always_comb begin
        zc = r_p[32 +: ZW];
        if (!r_pos) begin
            z_new = '0;
        end else if (r_over) begin
            z_new = top;
        end else begin
            z_new = (zc > top) ? top : zc;
        end
    end

    // eight restoring steps per cycle against a divisor below MAX_ORDER
    always_comb begin
        logic [SW:0]    r2;
        logic [DIG-1:0] dg;
        logic [SW-1:0]  rm;
        dg = r_dvd[DVP-1 -: DIG];
        rm = r_rem;
        qbits = '0;
        for (int b = DIG - 1; b >= 0; b--) begin
            r2 = {rm, dg[b]};
            if (r2 >= {1'b0, r_s}) begin
                r2 = r2 - {1'b0, r_s};
                qbits[b] = 1'b1;
            end
            rm = r2[SW-1:0];
        end
        rem_nx = rm;
    end

    always_comb begin
        for (int i = 0; i < WN; i++) begin
            wt[i] = round_wt(r_w[i]);
            nz[i] = (wt[i] != '0);
        end
        last_cur = 1'b1;
        for (int i = 1; i < WN; i++) begin
            if (nz[i] && (32'(i) + 32'(i_cmd.pos) < 32'(k_eff))) begin
                last_cur = 1'b0;
            end
        end
    end

    assign o_stat.cfg_bad  = cfg_bad;
    assign o_stat.k_eff    = k_eff;
    assign o_stat.term_on  = term_on;
    assign o_stat.div_last = (r_cnt == CNTW'(STEPS - 1));
    assign o_stat.nz_cur   = nz[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= ORDER_RST;
            r_bins  <= BINS_RST;
            r_min   <= MIN_RST;
            r_invr  <= INVR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_ORDER: r_order <= i_cfg_wdata[2:0];
                REG_BINS:  r_bins  <= i_cfg_wdata[6:0];
                REG_MIN:   r_min   <= i_cfg_wdata;
                REG_INVR:  r_invr  <= i_cfg_wdata;
                default:   r_order <= r_order;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: r_smp <= i_sample;
            OP_MAP1: begin
                r_p   <= ma * mb;
                r_pos <= !d[32] && (d != '0) && (r_invr != '0);
            end
            OP_MAP2: begin
                r_p    <= ma * mb;
                r_over <= (r_p[PW-1:32] != '0);
            end
            OP_MAP3: begin
                r_z   <= z_new;
                r_acc <= '0;
                for (int i = 0; i < WN; i++) begin
                    r_w[i] <= (32'(i) == 32'(k_eff) - 1) ? ONE_Q32 : '0;
                end
            end
            OP_TERM: begin
                r_p <= ma * mb;
                r_s <= SW'(t_hi - t_lo);
            end
            OP_DLOAD: begin
                r_dvd <= r_p[16 +: DVP];
                r_quo <= '0;
                r_rem <= '0;
                r_cnt <= '0;
            end
            OP_DSTEP: begin
                r_dvd <= r_dvd << DIG;
                r_quo <= {r_quo[DVP-DIG-1:0], qbits};
                r_rem <= rem_nx;
                r_cnt <= r_cnt + 1'b1;
            end
            OP_ACC: r_acc <= r_acc + r_quo[BVW-1:0];
            OP_STORE, OP_ROT: begin
                // rotate the first k entries; new value enters at k-1
                for (int i = 0; i < WN - 1; i++) begin
                    if (32'(i) < 32'(k_eff) - 1) begin
                        r_w[i] <= r_w[i+1];
                    end else if (32'(i) == 32'(k_eff) - 1) begin
                        r_w[i] <= (i_cmd.op == OP_STORE) ? r_acc : r_w[0];
                    end
                end
                r_acc <= '0;
            end
            OP_OUT: begin
                o_bin_index <= 6'(32'(base) + 32'(i_cmd.pos));
                o_weight    <= wt[0];
                o_last      <= last_cur;
            end
            default: r_cnt <= r_cnt;
        endcase
    end

endmodule

// ===== rtl/bbw_ctrl.sv =====
// Controller FSM: sequences mapping, Cox-de Boor terms, division and emission.
// Drives the datapath through t_cmd and reads t_stat. Depends on bbw_pkg.
module bbw_ctrl import bbw_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  logic  i_out_ready,
    output logic  o_out_valid,
    output t_cmd  o_cmd,
    input  t_stat i_stat
);

    typedef enum logic [3:0] {
        S_IDLE, S_MAP1, S_MAP2, S_MAP3, S_TERM, S_DLOAD, S_DIV, S_ACC,
        S_NEXT, S_EMIT, S_WAIT
    } t_state;

    t_state           r_state;
    logic [ORD_W-1:0] r_lvl;
    logic [ORD_W-1:0] r_pos;
    logic             r_half;
    logic             r_out_valid;
    logic [ORD_W-1:0] km1;
    logic             pos_end;

    assign km1         = i_stat.k_eff - 1'b1;
    assign pos_end     = (r_pos == km1);
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd.lvl  = r_lvl;
        o_cmd.pos  = r_pos;
        o_cmd.half = r_half;
        case (r_state)
            S_IDLE:  o_cmd.op = i_in_valid ? OP_LOAD : OP_NONE;
            S_MAP1:  o_cmd.op = OP_MAP1;
            S_MAP2:  o_cmd.op = OP_MAP2;
            S_MAP3:  o_cmd.op = OP_MAP3;
            S_TERM:  o_cmd.op = OP_TERM;
            S_DLOAD: o_cmd.op = OP_DLOAD;
            S_DIV:   o_cmd.op = OP_DSTEP;
            S_ACC:   o_cmd.op = OP_ACC;
            S_NEXT:  o_cmd.op = r_half ? OP_STORE : OP_NONE;
            S_EMIT:  o_cmd.op = i_stat.nz_cur ? OP_OUT : (pos_end ? OP_NONE : OP_ROT);
            S_WAIT:  o_cmd.op = (i_out_ready && !pos_end) ? OP_ROT : OP_NONE;
            default: o_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lvl       <= '0;
            r_pos       <= '0;
            r_half      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    // bad order/bin setup: sample is taken and yields nothing
                    if (i_in_valid && !i_stat.cfg_bad) begin
                        r_state <= S_MAP1;
                    end
                end
                S_MAP1: r_state <= S_MAP2;
                S_MAP2: r_state <= S_MAP3;
                S_MAP3: begin
                    r_lvl   <= ORD_W'(1);
                    r_pos   <= '0;
                    r_half  <= 1'b0;
                    r_state <= (i_stat.k_eff == ORD_W'(1)) ? S_EMIT : S_TERM;
                end
                S_TERM:  r_state <= i_stat.term_on ? S_DLOAD : S_NEXT;
                S_DLOAD: r_state <= S_DIV;
                S_DIV: begin
                    if (i_stat.div_last) begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC: r_state <= S_NEXT;
                S_NEXT: begin
                    if (!r_half) begin
                        r_half  <= 1'b1;
                        r_state <= S_TERM;
                    end else begin
                        r_half <= 1'b0;
                        if (pos_end) begin
                            r_pos <= '0;
                            if (r_lvl == km1) begin
                                r_state <= S_EMIT;
                            end else begin
                                r_lvl   <= r_lvl + 1'b1;
                                r_state <= S_TERM;
                            end
                        end else begin
                            r_pos   <= r_pos + 1'b1;
                            r_state <= S_TERM;
                        end
                    end
                end
                S_EMIT: begin
                    if (i_stat.nz_cur) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_WAIT;
                    end else if (pos_end) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_pos <= r_pos + 1'b1;
                    end
                end
                S_WAIT: begin
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                        if (pos_end) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_pos   <= r_pos + 1'b1;
                            r_state <= S_EMIT;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/bspline_basis_weights_core.sv =====
// Top level of the B-spline basis weight block: stream ports, config port,
// controller and datapath. Depends on bbw_pkg, bbw_ctrl, bbw_dp.
//
// Each sample beat is offset by data_min, scaled by inv_range into the knot
// range and run through the Cox-de Boor recursion of the configured order on a
// uniform clamped knot vector; one output beat leaves per basis function with a
// non-zero rounded weight, in ascending bin order, tlast on the final one. One
// sample is processed at a time. Mapping runs through the MAP1, MAP2 and MAP3
// states, then the recursion walks (k-1)*k*2 term slots on one shared 33x33
// multiplier: a zero term passes TERM and NEXT, a live term passes TERM,
// DLOAD, S division steps, ACC and NEXT; the long division runs at 8 bits per
// cycle, so S = ceil((clog2(MAX_BINS+1)+33)/8) (S = 5 at default sizes).
// Emission then scans k window slots, waiting on the output handshake for each
// non-zero one.
module bspline_basis_weights_core import bbw_pkg::*; #(
    parameter int MAX_ORDER = MAX_ORDER_DEF,
    parameter int MAX_BINS  = MAX_BINS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_wdata,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [31:0]       s_axis_tdata,   // [31:0] sample
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [23:0]       m_axis_tdata,   // [5:0] bin_index, [22:6] weight, [23] zero
    output logic              m_axis_tlast
);

    t_cmd        cmd;
    t_stat       stat;
    logic [5:0]  bin_index;
    logic [16:0] weight;

    bbw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    bbw_dp #(
        .MAX_ORDER (MAX_ORDER),
        .MAX_BINS  (MAX_BINS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_sample    ($signed(s_axis_tdata)),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_bin_index (bin_index),
        .o_weight    (weight),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, weight, bin_index};

endmodule

// ===== bench/bspline_basis_weights_core_tb.sv =====
// Self-checking bench for bspline_basis_weights_core: directed table, then random samples
// over many register settings, checked beat by beat against an in-bench basis predictor.
// Depends on bbw_pkg and the RTL only.
module bspline_basis_weights_core_tb;
    import bbw_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CYCLE_LIMIT = 1_000_000;
    localparam int  SETTLE      = 300;   // > worst sample latency
    localparam int  BBW_LEN     = 68;

    typedef struct packed {
        logic [5:0]  bin;
        logic [16:0] weight;
        logic        last;
    } t_weight_beat;

    typedef enum logic {ROW_CFG, ROW_SAMPLE} t_row_kind;

    typedef struct {
        t_row_kind          kind;
        logic [CFG_AW-1:0]  addr;
        logic [31:0]        value;
        int                 n_exp;    // -1: predictor only
        logic [5:0]         bin_exp;
        logic [16:0]        w_exp;
    } t_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [CFG_AW-1:0] i_cfg_addr = '0;
    logic [CFG_DW-1:0] i_cfg_wdata = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [31:0]       s_axis_tdata = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [23:0]       m_axis_tdata;
    logic              m_axis_tlast;

    // register mirror
    logic [2:0]  cfg_order = ORDER_RST;
    logic [6:0]  cfg_bins  = BINS_RST;
    logic [31:0] cfg_min   = MIN_RST;
    logic [31:0] cfg_invr  = INVR_RST;

    t_weight_beat weight_q[$];
    t_row         rows[$];
    int  n_mismatch = 0;
    int  sample_count = 0;
    int  n_beats = 0;
    int  n_settings = 0;
    int  cycles = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  long_hold_req = 1'b0;

    bspline_basis_weights_core uut (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_addr, .i_cfg_wdata,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
    );

    function automatic longint unsigned knot_at(longint unsigned i, longint unsigned k,
                                                longint unsigned nb);
        if (i < k) return 0;
        if (i < nb) return i - k + 1;
        return nb - k + 1;
    endfunction

    // Cox-de Boor on the clamped integer knot vector, Q.32 basis values
    function automatic int basis_weights(input logic [31:0] smp, output t_weight_beat res [4]);
        longint unsigned k, nb, tmax, top, z, nk, loc, ud, prod, sum, wv;
        longint unsigned ti, tip, ti1, tip1;
        longint signed   sv, mv, d;
        longint unsigned bv [BBW_LEN];
        int n;
        n = 0;
        for (int i = 0; i < 4; i++) res[i] = '0;
        k  = (cfg_order > 4) ? 4 : cfg_order;
        nb = (cfg_bins > 64) ? 64 : cfg_bins;
        if (k == 0 || nb < k) return 0;
        tmax = nb - k + 1;
        top  = (tmax << 16) - 1;
        sv = $signed(smp);
        mv = $signed(cfg_min);
        d  = sv - mv;
        if (d <= 0 || cfg_invr == 0) begin
            z = 0;
        end else begin
            ud = d;
            if (ud >= 64'h1_0000_0000) begin
                z = top;
            end else begin
                prod = ud * cfg_invr;
                z = (prod >= 64'h1_0000_0000) ? top : ((prod * tmax) >> 32);
            end
        end
        if (z > top) z = top;
        nk = nb + k;
        loc = 0;
        for (longint unsigned i = 0; i < nk; i++)
            if (z >= (knot_at(i, k, nb) << 16)) loc = i;
        for (int i = 0; i < BBW_LEN; i++) bv[i] = 0;
        if (loc + 1 < nk) bv[loc] = 64'h1_0000_0000;
        for (longint unsigned p = 1; p < k; p++) begin
            for (longint unsigned i = 0; i < nk - 1 - p; i++) begin
                sum  = 0;
                ti   = knot_at(i, k, nb);
                tip  = knot_at(i + p, k, nb);
                ti1  = knot_at(i + 1, k, nb);
                tip1 = knot_at(i + p + 1, k, nb);
                if (bv[i] != 0 && tip > ti && z >= (ti << 16))
                    sum += ((z - (ti << 16)) * bv[i]) / ((tip - ti) << 16);
                if (bv[i + 1] != 0 && tip1 > ti1 && (tip1 << 16) >= z)
                    sum += (((tip1 << 16) - z) * bv[i + 1]) / ((tip1 - ti1) << 16);
                bv[i] = sum;
            end
        end
        for (longint unsigned i = 0; i < nb; i++) begin
            wv = (bv[i] + 32768) >> 16;
            if (wv > 65536) wv = 65536;
            if (wv != 0 && n < 4) begin
                res[n].bin    = i[5:0];
                res[n].weight = wv[16:0];
                res[n].last   = 1'b0;
                n++;
            end
        end
        if (n > 0) res[n-1].last = 1'b1;
        return n;
    endfunction

    initial begin
        forever begin
            #5 i_clk = ~i_clk;
            if (i_clk) begin
                cycles++;
                if (cycles > CYCLE_LIMIT) begin
                    $display("timeout after %0d cycles, %0d weights outstanding",
                             cycles, weight_q.size());
                    $display("bspline_basis_weights_core_tb NOT OK");
                    $finish;
                end
            end
        end
    end

    // receiver: random stalls plus one long hold-off on request
    initial begin : rx_side
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req && hold_left == 0) begin
                hold_left = 1500;
                long_hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // predict on accepted samples, check accepted weight beats
    always @(posedge i_clk) begin
        t_weight_beat got, want;
        t_weight_beat res [4];
        int n;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                n_beats++;
                got = {m_axis_tdata[5:0], m_axis_tdata[22:6], m_axis_tlast};
                if (weight_q.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("unexpected beat bin=%0d w=%0d last=%0b",
                                 got.bin, got.weight, got.last);
                end else begin
                    want = weight_q.pop_front();
                    if (got !== want || m_axis_tdata[23] !== 1'b0) begin
                        n_mismatch++;
                        if (n_mismatch <= 10)
                            $display("mismatch: exp bin=%0d w=%0d last=%0b, got bin=%0d w=%0d last=%0b pad=%b",
                                     want.bin, want.weight, want.last,
                                     got.bin, got.weight, got.last, m_axis_tdata[23]);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                sample_count++;
                n = basis_weights(s_axis_tdata, res);
                for (int i = 0; i < n; i++) weight_q.push_back(res[i]);
            end
        end
    end

    task automatic drain();
        while (weight_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [31:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        case (addr)
            REG_ORDER: cfg_order = value[2:0];
            REG_BINS:  cfg_bins  = value[6:0];
            REG_MIN:   cfg_min   = value;
            default:   cfg_invr  = value;
        endcase
    endtask

    task automatic send_sample(input logic [31:0] smp);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic add_row(input t_row_kind kind, input logic [CFG_AW-1:0] addr,
                           input logic [31:0] value, input int n_exp,
                           input logic [5:0] bin_exp, input logic [16:0] w_exp);
        t_row r;
        r.kind = kind; r.addr = addr; r.value = value;
        r.n_exp = n_exp; r.bin_exp = bin_exp; r.w_exp = w_exp;
        rows.push_back(r);
    endtask

    task automatic random_settings(input bit extreme);
        logic [2:0]  o;
        logic [6:0]  b;
        logic [31:0] m, r;
        int sel;
        drain();
        if (extreme) begin
            o = 3'd4; b = 7'd64; m = 32'h8000_0000; r = 32'hFFFF_FFFF;
        end else begin
            o = ($urandom_range(9) < 7) ? 3'($urandom_range(1, 4)) : 3'($urandom_range(0, 7));
            sel = $urandom_range(99);
            if (sel < 70) b = 7'($urandom_range((o > 4) ? 4 : o, 20));
            else if (sel < 85) b = 7'($urandom_range(0, 127));
            else b = ($urandom_range(1)) ? 7'd64 : 7'd127;
            m = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 1 << 20) - (1 << 19);
            sel = $urandom_range(99);
            if (sel < 80) r = $urandom_range(1 << 12, 1 << 20);
            else if (sel < 93) r = $urandom;
            else r = 32'd0;
        end
        write_reg(REG_ORDER, {29'd0, o} | ($urandom & 32'hFFFF_FFF8));
        write_reg(REG_BINS,  {25'd0, b} | ($urandom & 32'hFFFF_FF80));
        write_reg(REG_MIN,   m);
        write_reg(REG_INVR,  r);
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    function automatic logic [31:0] random_sample();
        longint unsigned span;
        if ($urandom_range(4) == 0 || cfg_invr == 0) return $urandom;
        span = 64'h1_0000_0000 / cfg_invr;
        span = span + span / 8;
        if (span > 32'hFFFF_FFFF) span = 32'hFFFF_FFFF;
        return cfg_min + $urandom_range(0, span[31:0]);
    endfunction

    initial begin : stim
        t_weight_beat res [4];
        int n;
        int idle_plan [3][2] = '{'{25, 85}, '{85, 25}, '{0, 0}};

        // reset values: sample at zero sits on the first knot
        add_row(ROW_SAMPLE, 0, 32'h0000_0000, 1, 6'd0, 17'd65536);
        add_row(ROW_SAMPLE, 0, 32'h8000_0000, 1, 6'd0, 17'd65536);
        add_row(ROW_SAMPLE, 0, 32'h7FFF_FFFF, -1, 0, 0);
        add_row(ROW_SAMPLE, 0, 32'h0000_8000, -1, 0, 0);
        add_row(ROW_SAMPLE, 0, 32'h0000_3000, -1, 0, 0);
        add_row(ROW_CFG, REG_INVR, 32'h0, 0, 0, 0);
        add_row(ROW_SAMPLE, 0, 32'h1234_5678, 1, 6'd0, 17'd65536);
        add_row(ROW_CFG, REG_INVR, 32'hFFFF_FFFF, 0, 0, 0);
        add_row(ROW_SAMPLE, 0, 32'h0000_0001, -1, 0, 0);
        add_row(ROW_SAMPLE, 0, 32'h7FFF_FFFF, -1, 0, 0);
        add_row(ROW_CFG, REG_ORDER, 32'd1, 0, 0, 0);
        add_row(ROW_SAMPLE, 0, 32'h0000_0000, 1, 6'd0, 17'd65536);
        add_row(ROW_SAMPLE, 0, 32'h7FFF_FFFF, 1, 6'd9, 17'd65536);
        add_row(ROW_CFG, REG_ORDER, 32'd0, 0, 0, 0);
        add_row(ROW_SAMPLE, 0, 32'h0000_0005, 0, 0, 0);
        add_row(ROW_CFG, REG_ORDER, 32'd7, 0, 0, 0);
        add_row(ROW_SAMPLE, 0, 32'h0000_0000, 1, 6'd0, 17'd65536);
        add_row(ROW_CFG, REG_BINS, 32'd127, 0, 0, 0);
        add_row(ROW_SAMPLE, 0, 32'h7FFF_FFFF, -1, 0, 0);
        add_row(ROW_SAMPLE, 0, 32'h0400_0000, -1, 0, 0);
        add_row(ROW_CFG, REG_BINS, 32'd2, 0, 0, 0);
        add_row(ROW_SAMPLE, 0, 32'h0000_1000, 0, 0, 0);
        add_row(ROW_CFG, REG_ORDER, 32'd1, 0, 0, 0);
        add_row(ROW_CFG, REG_BINS, 32'd1, 0, 0, 0);
        add_row(ROW_SAMPLE, 0, 32'h7FFF_FFFF, 1, 6'd0, 17'd65536);
        add_row(ROW_CFG, REG_MIN, 32'h7FFF_FFFF, 0, 0, 0);
        add_row(ROW_SAMPLE, 0, 32'h8000_0000, 1, 6'd0, 17'd65536);
        add_row(ROW_CFG, REG_BINS, 32'd64, 0, 0, 0);
        add_row(ROW_CFG, REG_ORDER, 32'd4, 0, 0, 0);
        add_row(ROW_CFG, REG_MIN, 32'h8000_0000, 0, 0, 0);
        add_row(ROW_SAMPLE, 0, 32'h7FFF_FFFF, -1, 0, 0);
        add_row(ROW_SAMPLE, 0, 32'hC000_0000, -1, 0, 0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG) begin
                s_axis_tvalid <= 1'b0;
                drain();
                write_reg(rows[i].addr, rows[i].value);
                i_cfg_we <= 1'b0;
            end else begin
                if (rows[i].n_exp >= 0) begin
                    n = basis_weights(rows[i].value, res);
                    if (n != rows[i].n_exp || (n > 0 && (res[0].bin != rows[i].bin_exp ||
                        res[0].weight != rows[i].w_exp))) begin
                        n_mismatch++;
                        if (n_mismatch <= 10)
                            $display("table row %0d: exp %0d beats bin=%0d w=%0d, predicted %0d",
                                     i, rows[i].n_exp, rows[i].bin_exp, rows[i].w_exp, n);
                    end
                end
                send_sample(rows[i].value);
            end
        end

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct  = idle_plan[ph][0];
            recv_stall_pct = idle_plan[ph][1];
            for (int sub = 0; sub < 4; sub++) begin
                s_axis_tvalid <= 1'b0;
                random_settings(ph == 0 && sub == 0);
                for (int j = 0; j < 42; j++) begin
                    // sender keeps offering while the output side is held off
                    if (ph == 2 && sub == 1 && j == 5) long_hold_req = 1'b1;
                    if (ph == 2 && sub == 2 && j == 20) begin
                        s_axis_tvalid <= 1'b0;
                        while (weight_q.size() != 0) @(posedge i_clk);
                    end
                    send_sample(random_sample());
                end
            end
        end
        s_axis_tvalid <= 1'b0;
        drain();

        $display("%0d samples, %0d weight beats, %0d random register settings",
                 sample_count, n_beats, n_settings);
        if (n_mismatch == 0 && weight_q.size() == 0) begin
            $display("bspline_basis_weights_core_tb OK");
        end else begin
            $display("%0d mismatches, %0d weights never seen", n_mismatch, weight_q.size());
            $display("bspline_basis_weights_core_tb NOT OK");
        end
        $finish;
    end

endmodule
